// ===== src/gab_pkg.sv =====
`default_nettype none

package gab_pkg;

  localparam int unsigned MAX_ENTRIES_DEF   = 32;
  localparam int unsigned NUM_DET_DEF       = 16;
  localparam int unsigned CRYST_PER_DET_DEF = 4;

  localparam int unsigned CRYSTAL_W = 8;
  localparam int unsigned TIME_W    = 52;
  localparam int unsigned CFD_W     = 16;
  localparam int unsigned ENERGY_W  = 20;
  localparam int unsigned DET_W     = 4;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned THR_W     = 20;
  localparam int unsigned GATE_W    = 52;
  localparam int unsigned CFG_W     = 52;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(160);
  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(3200);

  typedef enum logic [0:0] {
    REG_ENERGY_THRESHOLD = 1'b0,
    REG_TIME_GATE        = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [DET_W-1:0]    detector;
    logic [SUM_W-1:0]    sum;
    logic [ENERGY_W-1:0] peak;
    logic [TIME_W-1:0]   time_v;
    logic [CFD_W-1:0]    cfd;
    logic [COUNT_W-1:0]  crystals;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/gamma_addback_builder.sv =====
`default_nettype none

// Addback builder for clover detectors. Crystal hits of one event arrive one
// transaction at a time on the slave stream; tlast marks the last hit of the
// event. A hit below the energy threshold or outside the detector range is
// ignored. An accepted hit joins the first entry of its detector whose peak
// time lies strictly within the time gate, or opens a new entry; with the
// entry table full it is dropped and the overflow flag is raised. After the
// last hit all entries leave on the master stream in creation order (one
// empty result with tuser has_entry low if there are none), tlast on the
// final one, and the table is cleared. Entries live in a single-port-read
// RAM scanned by one compare unit: each entry is read, its time difference
// and detector match are registered and then checked, and the hit updates
// the matching entry or writes a new one. Each result is read from the RAM,
// loaded into the output register and held until m_axis_tready. The block
// takes no hit until the current one, and its results, are done.
module gamma_addback_builder
  import gab_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES           = MAX_ENTRIES_DEF,
  parameter int unsigned NUM_DETECTORS         = NUM_DET_DEF,
  parameter int unsigned CRYSTALS_PER_DETECTOR = CRYST_PER_DET_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_addr_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // crystal_id, hit_time, cfd_fraction, cal_energy
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tlast,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // detector_id, energy_sum, peak_energy, peak_time, peak_cfd, crystal_count, zero pad
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  // has_entry, table_overflow
  output      logic [OUT_USER_W-1:0] m_axis_tuser,
  output      logic                  m_axis_tlast
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_READ = 9'b000000010,
    ST_DIFF = 9'b000000100,
    ST_CHK  = 9'b000001000,
    ST_UPD  = 9'b000010000,
    ST_NEW  = 9'b000100000,
    ST_ERD  = 9'b001000000,
    ST_ELD  = 9'b010000000,
    ST_EOUT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [THR_W-1:0]    thr_q;
  logic [GATE_W-1:0]   gate_q;
  logic [DET_W-1:0]    hit_det_q;
  logic [TIME_W-1:0]   hit_time_q;
  logic [CFD_W-1:0]    hit_cfd_q;
  logic [ENERGY_W-1:0] hit_e_q;
  logic                hit_eoe_q;
  logic [CW-1:0]       used_q;
  logic [CW-1:0]       idx_q;
  logic                ovf_q;
  logic [TIME_W-1:0]   diff_q;
  logic                det_eq_q;
  entry_t              out_q;
  logic                out_has_q;
  logic                out_last_q;

  logic [CRYSTAL_W-1:0] in_crystal;
  logic [TIME_W-1:0]    in_time;
  logic [CFD_W-1:0]     in_cfd;
  logic [ENERGY_W-1:0]  in_energy;
  logic [DET_W-1:0]     in_det;
  logic                 in_det_ok;
  logic                 in_ok;
  logic                 in_fire;
  logic                 out_fire;

  entry_t          rd_entry;
  entry_t          merged;
  entry_t          fresh;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [SUM_W:0]  sum_ext;
  logic            match;
  logic            idx_at_end;
  logic            table_full;

  assign in_crystal = s_axis_tdata[CRYSTAL_W-1:0];
  assign in_time    = s_axis_tdata[CRYSTAL_W +: TIME_W];
  assign in_cfd     = s_axis_tdata[CRYSTAL_W+TIME_W +: CFD_W];
  assign in_energy  = s_axis_tdata[CRYSTAL_W+TIME_W+CFD_W +: ENERGY_W];

  // detector number by range compare against constant crystal bounds
  always_comb begin
    in_det    = '0;
    in_det_ok = 1'b0;
    for (int unsigned d = 0; d < NUM_DETECTORS; d++) begin
      if (({1'b0, in_crystal} >= (CRYSTAL_W+1)'(d * CRYSTALS_PER_DETECTOR)) &&
          ({1'b0, in_crystal} < (CRYSTAL_W+1)'((d + 1) * CRYSTALS_PER_DETECTOR))) begin
        in_det    = DET_W'(d);
        in_det_ok = 1'b1;
      end
    end
  end

  assign in_ok      = (in_energy >= thr_q) && in_det_ok;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_EOUT);
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign match      = det_eq_q && (diff_q < gate_q);
  assign idx_at_end = ({1'b0, idx_q} + (CW+1)'(1)) == {1'b0, used_q};
  assign table_full = (used_q == CW'(MAX_ENTRIES));

  // join: saturating sum and count, peak follows the largest crystal
  always_comb begin
    sum_ext = {1'b0, rd_entry.sum} + (SUM_W+1)'(hit_e_q);
    merged  = rd_entry;
    merged.sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    if (hit_e_q > rd_entry.peak) begin
      merged.peak   = hit_e_q;
      merged.time_v = hit_time_q;
      merged.cfd    = hit_cfd_q;
    end
    if (rd_entry.crystals != {COUNT_W{1'b1}}) begin
      merged.crystals = rd_entry.crystals + COUNT_W'(1);
    end
  end

  always_comb begin
    fresh.detector = hit_det_q;
    fresh.sum      = SUM_W'(hit_e_q);
    fresh.peak     = hit_e_q;
    fresh.time_v   = hit_time_q;
    fresh.cfd      = hit_cfd_q;
    fresh.crystals = COUNT_W'(1);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = merged;
    if (state_q == ST_UPD) begin
      ram_we = 1'b1;
    end else if (state_q == ST_NEW) begin
      ram_we    = !table_full;
      ram_waddr = used_q[AW-1:0];
      ram_wdata = fresh;
    end
  end

  gab_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ok && used_q != '0) begin
            state_d = ST_READ;
          end else if (in_ok) begin
            state_d = ST_NEW;
          end else if (s_axis_tlast) begin
            state_d = ST_ERD;
          end
        end
      end
      ST_READ: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_CHK;
      ST_CHK: begin
        if (match) begin
          state_d = ST_UPD;
        end else if (idx_at_end) begin
          state_d = ST_NEW;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_UPD, ST_NEW: state_d = hit_eoe_q ? ST_ERD : ST_IDLE;
      ST_ERD: state_d = ST_ELD;
      ST_ELD: state_d = ST_EOUT;
      ST_EOUT: begin
        if (out_fire) begin
          state_d = out_last_q ? ST_IDLE : ST_ERD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q   <= THR_RESET;
      gate_q  <= GATE_RESET;
      used_q  <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_ENERGY_THRESHOLD: thr_q  <= cfg_wdata_i[THR_W-1:0];
          REG_TIME_GATE:        gate_q <= cfg_wdata_i[GATE_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: idx_q <= '0;
        ST_CHK: begin
          if (!match && !idx_at_end) begin
            idx_q <= idx_q + CW'(1);
          end
        end
        ST_UPD, ST_NEW: begin
          idx_q <= '0;
          if (state_q == ST_NEW) begin
            if (table_full) begin
              ovf_q <= 1'b1;
            end else begin
              used_q <= used_q + CW'(1);
            end
          end
        end
        ST_EOUT: begin
          if (out_fire) begin
            if (out_last_q) begin
              used_q <= '0;
              ovf_q  <= 1'b0;
              idx_q  <= '0;
            end else begin
              idx_q <= idx_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hit_det_q  <= in_det;
      hit_time_q <= in_time;
      hit_cfd_q  <= in_cfd;
      hit_e_q    <= in_energy;
      hit_eoe_q  <= s_axis_tlast;
    end
    if (state_q == ST_DIFF) begin
      det_eq_q <= (rd_entry.detector == hit_det_q);
      diff_q   <= (hit_time_q >= rd_entry.time_v) ? hit_time_q - rd_entry.time_v
                                                   : rd_entry.time_v - hit_time_q;
    end
    if (state_q == ST_ELD) begin
      if (used_q == '0) begin
        out_q      <= '0;
        out_has_q  <= 1'b0;
        out_last_q <= 1'b1;
      end else begin
        out_q      <= rd_entry;
        out_has_q  <= 1'b1;
        out_last_q <= idx_at_end;
      end
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W-EW)'(0), out_q.crystals, out_q.cfd, out_q.time_v,
                         out_q.peak, out_q.sum, out_q.detector};
  assign m_axis_tuser = {ovf_q, out_has_q};
  assign m_axis_tlast = out_last_q;

endmodule

`default_nettype wire

// ===== src/gab_ram.sv =====
`default_nettype none

module gab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AW-1:0]          waddr_i,
  input  wire logic [WIDTH-1:0]       wdata_i,
  input  wire logic [AW-1:0]          raddr_i,
  output      logic [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
